// File: design/grl_pkg.sv
// ----------------------------------------------------------------------------
// grl_pkg: glyph run layout shared types and constants
// Glyph profile record, profile lookup, CSR indices and saturation helpers.
// ----------------------------------------------------------------------------
package grl_pkg;

   typedef enum logic [2:0] {
      CSR_FONT_SIZE   = 3'd0,
      CSR_SUB_SCALE   = 3'd1,
      CSR_SUP_SCALE   = 3'd2,
      CSR_SUB_DROP    = 3'd3,
      CSR_SUP_RISE    = 3'd4,
      CSR_TRACKING    = 3'd5
   } csr_index_type;

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_SUB    = 2'd1;
   localparam logic [1:0] KIND_SUP    = 2'd2;

   // Em metrics in Q2.14
   typedef struct packed {
      logic signed [15:0] adv;
      logic signed [15:0] il;
      logic signed [15:0] it;
      logic signed [15:0] ir;
      logic signed [15:0] ib;
      logic signed [15:0] chg;    // sign recentre offset, zero unless plus or minus
      logic [2:0]         shape;
      logic               vis;
   } glyph_type;

   // hundredths of an em to Q2.14, nearest, ties away from zero
   function automatic int em100(input int h);
      int p;
      begin
         p = h * 16384;
         em100 = (p >= 0) ? (p + 50) / 100 : (p - 50) / 100;
      end
   endfunction

   function automatic int em200(input int h);
      int p;
      begin
         p = h * 16384;
         em200 = (p >= 0) ? (p + 100) / 200 : (p - 100) / 200;
      end
   endfunction

   localparam logic signed [15:0] PAD_Q14 = 16'(em100(9));

   function automatic glyph_type mk(input int shape, input int adv, input int il,
                                    input int it, input int ir, input int ib,
                                    input int vis, input int chg_en);
      glyph_type g;
      begin
         g.adv   = 16'(em100(adv));
         g.il    = 16'(em100(il));
         g.it    = 16'(em100(it));
         g.ir    = 16'(em100(ir));
         g.ib    = 16'(em100(ib));
         g.chg   = (chg_en != 0) ? 16'(em200(-71 - (it + ib))) : 16'sd0;
         g.shape = 3'(shape);
         g.vis   = 1'(vis);
         mk = g;
      end
   endfunction

   function automatic glyph_type glyph_lookup(input logic [20:0] cp);
      glyph_type g;
      begin
         unique case (cp)
            21'h20:   g = mk(0,28,0,0,0,0,0,0);
            21'h2B:   g = mk(0,58,0,-47,58,0,1,1);
            21'h2D:   g = mk(0,33,0,-32,33,0,1,1);
            21'h28:   g = mk(0,33,0,-73,33,21,1,0);
            21'h29:   g = mk(0,33,0,-73,33,21,1,0);
            21'h5B:   g = mk(0,28,0,-73,28,22,1,0);
            21'h5D:   g = mk(0,28,0,-73,28,22,1,0);
            21'h2E:   g = mk(0,28,0,-11,28,0,1,0);
            21'h2C:   g = mk(0,28,0,-11,28,15,1,0);
            21'h2F:   g = mk(0,28,-1,-73,29,2,1,0);
            21'h2219: g = mk(1,28,0,-31,28,0,1,0);
            21'h2022: g = mk(1,35,0,-47,35,0,1,0);
            21'h41:   g = mk(0,67,0,-73,67,0,1,0);
            21'h42:   g = mk(0,67,0,-73,67,1,1,0);
            21'h43:   g = mk(1,72,0,-75,72,2,1,0);
            21'h44:   g = mk(0,72,0,-73,72,0,1,0);
            21'h45:   g = mk(0,67,0,-73,67,0,1,0);
            21'h46:   g = mk(2,61,0,-73,61,0,1,0);
            21'h47:   g = mk(1,78,0,-75,78,2,1,0);
            21'h48:   g = mk(0,72,0,-73,72,0,1,0);
            21'h49:   g = mk(0,28,0,-73,28,0,1,0);
            21'h4A:   g = mk(0,50,0,-73,50,2,1,0);
            21'h4B:   g = mk(0,67,0,-73,67,0,1,0);
            21'h4C:   g = mk(3,56,0,-73,56,0,1,0);
            21'h4D:   g = mk(0,83,0,-73,83,0,1,0);
            21'h4E:   g = mk(0,72,0,-73,72,0,1,0);
            21'h4F:   g = mk(1,78,0,-75,78,2,1,0);
            21'h50:   g = mk(2,67,0,-73,67,0,1,0);
            21'h51:   g = mk(1,78,0,-75,78,6,1,0);
            21'h52:   g = mk(0,72,0,-73,72,0,1,0);
            21'h53:   g = mk(0,67,0,-75,67,2,1,0);
            21'h54:   g = mk(0,61,0,-73,61,0,1,0);
            21'h55:   g = mk(0,72,0,-73,72,2,1,0);
            21'h56:   g = mk(0,67,0,-73,67,0,1,0);
            21'h57:   g = mk(0,94,0,-73,94,0,1,0);
            21'h58:   g = mk(0,67,0,-73,67,0,1,0);
            21'h59:   g = mk(0,67,0,-73,67,0,1,0);
            21'h5A:   g = mk(0,61,0,-73,61,0,1,0);
            21'h61:   g = mk(0,56,0,-54,56,2,1,0);
            21'h62:   g = mk(3,56,0,-73,56,2,1,0);
            21'h63:   g = mk(1,50,0,-54,50,2,1,0);
            21'h64:   g = mk(4,56,0,-73,56,2,1,0);
            21'h65:   g = mk(1,56,0,-54,56,2,1,0);
            21'h66:   g = mk(0,28,0,-73,28,0,1,0);
            21'h67:   g = mk(1,56,0,-54,56,23,1,0);
            21'h68:   g = mk(3,56,0,-73,56,0,1,0);
            21'h69:   g = mk(0,22,0,-71,22,0,1,0);
            21'h6A:   g = mk(0,22,-2,-71,22,22,1,0);
            21'h6B:   g = mk(0,50,0,-73,51,0,1,0);
            21'h6C:   g = mk(0,22,0,-73,22,0,1,0);
            21'h6D:   g = mk(0,83,0,-54,83,0,1,0);
            21'h6E:   g = mk(0,56,0,-54,56,0,1,0);
            21'h6F:   g = mk(1,56,0,-54,56,2,1,0);
            21'h70:   g = mk(0,56,0,-54,56,22,1,0);
            21'h71:   g = mk(5,56,0,-54,56,23,1,0);
            21'h72:   g = mk(0,33,0,-54,33,0,1,0);
            21'h73:   g = mk(0,50,0,-54,50,2,1,0);
            21'h74:   g = mk(0,28,0,-66,28,1,1,0);
            21'h75:   g = mk(0,56,0,-52,56,2,1,0);
            21'h76:   g = mk(0,50,0,-52,50,0,1,0);
            21'h77:   g = mk(0,72,0,-52,72,0,1,0);
            21'h78:   g = mk(0,50,0,-52,50,0,1,0);
            21'h79:   g = mk(0,50,0,-52,50,22,1,0);
            21'h7A:   g = mk(0,50,0,-52,50,0,1,0);
            21'h30:   g = mk(1,56,0,-71,56,2,1,0);
            21'h31:   g = mk(0,56,0,-71,56,0,1,0);
            21'h32:   g = mk(0,56,0,-71,56,0,1,0);
            21'h33:   g = mk(0,56,0,-71,56,2,1,0);
            21'h34:   g = mk(0,56,0,-71,56,0,1,0);
            21'h35:   g = mk(0,56,0,-70,56,2,1,0);
            21'h36:   g = mk(1,56,0,-71,56,2,1,0);
            21'h37:   g = mk(0,56,0,-70,56,0,1,0);
            21'h38:   g = mk(1,56,0,-71,56,2,1,0);
            21'h39:   g = mk(1,56,0,-71,56,2,1,0);
            default:  g = mk(0,45,3,-40,38,2,1,0);
         endcase
         glyph_lookup = g;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      begin
         if (v > 36'sd2147483647)       sat32 = 32'sh7fffffff;
         else if (v < -36'sd2147483648) sat32 = 32'sh80000000;
         else                           sat32 = v[31:0];
      end
   endfunction

endpackage

// File: design/grl_mul.sv
// ----------------------------------------------------------------------------
// grl_mul: shared multiplier
// One signed 18 x 17 multiply a cycle with a registered product.
// ----------------------------------------------------------------------------
module grl_mul (
   input  logic               clock,
   input  logic signed [17:0] op_a,
   input  logic signed [16:0] op_b,
   output logic signed [34:0] prod_ff
);

   logic signed [34:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: design/glyph_run_layout_unit.sv
// ----------------------------------------------------------------------------
// glyph_run_layout_unit: places one glyph per transaction along a text run
// Flow: a request moves the sequencer from IDLE through the RUN steps to HOLD,
//   where the result is presented until rsp_tready takes it; no new request is
//   accepted until then. Nine products share one multiplier, one per cycle,
//   with a final step to settle the last.
// Reset (synchronous): idle, cursor at zero, configuration registers at their defaults.
// ----------------------------------------------------------------------------
module glyph_run_layout_unit (
   input  logic         clock,
   input  logic         reset,
   // request: [20:0] codepoint, [21] run_start, [53:22] run_start_x,
   //          [85:54] run baseline, [87:86] zero
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic [1:0]   req_tuser,   // [1:0] script_kind
   // response: [31:0] origin_x, [63:32] glyph_baseline, [95:64] advance,
   //           [127:96] ink_left, [159:128] ink_top, [191:160] ink_right,
   //           [223:192] ink_bottom, [254:224] pad_x, [285:255] pad_y,
   //           [301:286] scaled_size, [303:302] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [303:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // [2:0] glyph outline, [3] visible
   // configuration writes
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   localparam logic [3:0] STEP_SIZE   = 4'd0;
   localparam logic [3:0] STEP_SHIFT  = 4'd1;
   localparam logic [3:0] STEP_ADJ    = 4'd2;
   localparam logic [3:0] STEP_ADV    = 4'd3;
   localparam logic [3:0] STEP_IL     = 4'd4;
   localparam logic [3:0] STEP_IT     = 4'd5;
   localparam logic [3:0] STEP_IR     = 4'd6;
   localparam logic [3:0] STEP_IB     = 4'd7;
   localparam logic [3:0] STEP_PAD    = 4'd8;
   localparam logic [3:0] STEP_LAST   = 4'd9;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;

   // configuration registers
   logic [15:0] font_size_ff, sub_scale_ff, sup_scale_ff;
   logic [15:0] sub_drop_ff, sup_rise_ff, tracking_ff;

   // per-glyph working registers
   grl_pkg::glyph_type glyph_ff;
   logic [1:0]         kind_ff;
   logic               chg_en_ff;
   logic signed [31:0] baseline_ff;
   logic signed [31:0] cursor_ff;
   logic signed [31:0] origin_ff;
   logic [15:0]        size_ff;
   logic signed [31:0] shift_ff;
   logic signed [31:0] base_ff, adv_ff;
   logic signed [31:0] ink_l_ff, ink_t_ff, ink_r_ff, ink_b_ff;
   logic [30:0]        pad_ff;

   logic               req_fire;
   logic [1:0]         kind_norm;
   logic signed [31:0] rsx;
   logic signed [17:0] op_a;
   logic signed [16:0] op_b;
   logic signed [34:0] prod_ff;
   logic signed [34:0] rnd_w;
   logic signed [35:0] rnd_x;
   logic [34:0]        size_w;
   logic [15:0]        size_sat;
   logic [3:0]         prev_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_HOLD);

   // script kind three behaves as normal
   assign kind_norm = (req_tuser == 2'd3) ? grl_pkg::KIND_NORMAL : req_tuser;
   assign rsx       = req_tdata[53:22];

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               step_in  = STEP_SIZE;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SIZE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         font_size_ff <= 16'd1024;
         sub_scale_ff <= 16'd11469;
         sup_scale_ff <= 16'd11469;
         sub_drop_ff  <= 16'd3277;
         sup_rise_ff  <= 16'd6554;
         tracking_ff  <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            grl_pkg::CSR_FONT_SIZE: font_size_ff <= csr_wdata;
            grl_pkg::CSR_SUB_SCALE: sub_scale_ff <= csr_wdata;
            grl_pkg::CSR_SUP_SCALE: sup_scale_ff <= csr_wdata;
            grl_pkg::CSR_SUB_DROP:  sub_drop_ff  <= csr_wdata;
            grl_pkg::CSR_SUP_RISE:  sup_rise_ff  <= csr_wdata;
            grl_pkg::CSR_TRACKING:  tracking_ff  <= csr_wdata;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- operand select ----------------
   // Zero operands stand in for terms that do not apply; they round to zero.
   always_comb begin
      op_a = 18'sd0;
      op_b = {1'b0, size_ff};
      case (step_ff)
         STEP_SIZE: begin
            op_a = {2'b00, font_size_ff};
            case (kind_ff)
               grl_pkg::KIND_SUB: op_b = {1'b0, sub_scale_ff};
               grl_pkg::KIND_SUP: op_b = {1'b0, sup_scale_ff};
               default:           op_b = 17'sd16384;
            endcase
         end
         STEP_SHIFT: begin
            op_b = {1'b0, font_size_ff};
            case (kind_ff)
               grl_pkg::KIND_SUB: op_a = 18'(signed'(sub_drop_ff));
               grl_pkg::KIND_SUP: op_a = 18'(signed'(sup_rise_ff));
               default:           op_a = 18'sd0;
            endcase
         end
         STEP_ADJ: op_a = (chg_en_ff) ? 18'(glyph_ff.chg) : 18'sd0;
         STEP_ADV: op_a = 18'(glyph_ff.adv) + 18'(signed'(tracking_ff));
         STEP_IL:  op_a = 18'(glyph_ff.il);
         STEP_IT:  op_a = 18'(glyph_ff.it);
         STEP_IR:  op_a = 18'(glyph_ff.ir);
         STEP_IB:  op_a = 18'(glyph_ff.ib);
         STEP_PAD: op_a = (glyph_ff.vis) ? 18'(grl_pkg::PAD_Q14) : 18'sd0;
         default:  op_a = 18'sd0;
      endcase
   end

   grl_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // ---------------- product settle ----------------
   // Round half up by a sixteenth for pixel terms.
   assign rnd_w     = (prod_ff + 35'sd8) >>> 4;
   assign rnd_x     = 36'(rnd_w);
   assign size_w    = prod_ff + 35'd8192;
   assign size_sat  = (|size_w[34:30]) ? 16'hffff : size_w[29:14];
   assign prev_step = step_ff - 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 32'sd0;
      end else if (req_fire && req_tdata[21]) begin
         cursor_ff <= rsx;
      end else if (state_ff == ST_RUN && prev_step == STEP_ADV && step_ff != STEP_SIZE) begin
         cursor_ff <= grl_pkg::sat32(36'(origin_ff) + rnd_x);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         glyph_ff    <= grl_pkg::glyph_lookup(req_tdata[20:0]);
         kind_ff     <= kind_norm;
         chg_en_ff   <= (kind_norm != grl_pkg::KIND_NORMAL);
         baseline_ff <= req_tdata[85:54];
         origin_ff   <= (req_tdata[21]) ? rsx : cursor_ff;
      end
      if (state_ff == ST_RUN && step_ff != STEP_SIZE) begin
         case (prev_step)
            STEP_SIZE:  size_ff  <= size_sat;
            STEP_SHIFT: shift_ff <= (kind_ff == grl_pkg::KIND_SUB) ? rnd_w[31:0]
                                                                   : -rnd_w[31:0];
            STEP_ADJ:   base_ff  <= grl_pkg::sat32(36'(baseline_ff) + 36'(shift_ff) + rnd_x);
            STEP_ADV:   adv_ff   <= grl_pkg::sat32(rnd_x);
            STEP_IL:    ink_l_ff <= grl_pkg::sat32(36'(origin_ff) + rnd_x);
            STEP_IT:    ink_t_ff <= grl_pkg::sat32(36'(base_ff) + rnd_x);
            STEP_IR:    ink_r_ff <= grl_pkg::sat32(36'(origin_ff) + rnd_x);
            STEP_IB:    ink_b_ff <= grl_pkg::sat32(36'(base_ff) + rnd_x);
            STEP_PAD:   pad_ff   <= rnd_w[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- response ----------------
   assign rsp_tdata = {2'b00, size_ff, pad_ff, pad_ff, ink_b_ff, ink_r_ff, ink_t_ff,
                       ink_l_ff, adv_ff, base_ff, origin_ff};
   assign rsp_tuser = {glyph_ff.vis, glyph_ff.shape};

`ifndef SYNTHESIS
   a_fire_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_RUN) && (step_ff == STEP_SIZE))
      else $error("request transaction did not start the sequencer");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= STEP_LAST))
      else $error("sequencer step out of range");

   a_hidden_no_pad: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !glyph_ff.vis) |-> (pad_ff == 31'd0))
      else $error("invisible glyph carries padding");

   a_run_to_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (step_ff == STEP_LAST)) |=> rsp_tvalid)
      else $error("last step did not present a result");
`endif

endmodule
